[sv/pvq_pkg.sv]
// shared types for the positive value quantile block
package pvq_pkg;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_POS,
        S_SCAN,
        S_DECIDE,
        S_MUL,
        S_SUM,
        S_OUT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic start;
        logic scan_init;
        logic scan_step;
        logic decide;
        logic mul;
        logic sum;
        logic load;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic scan_last;
        logic bit_last;
        logic count_zero;
        logic out_full;
    } status_t;

    localparam int unsigned VALUE_W = 31;
    localparam int unsigned PROB_W  = 17;
    localparam int unsigned FRAC_W  = 16;
    localparam int unsigned OCNT_W  = 11;
    localparam logic [PROB_W-1:0] PROB_ONE  = 17'd65536;
    localparam logic [PROB_W-1:0] PROB_HALF = 17'd32768;
    localparam logic [4:0] TOP_BIT = 5'd30;

endpackage

[sv/positive_value_quantile.sv]
// top level of the positive value quantile block
//
// channel   dir  signals                     content
// s_axis    in   s_tvalid s_tready s_tdata   sample_value, s_tlast = column_end
// m_axis    out  m_tvalid m_tready m_tdata   anchor, count, none, overflow
// config    in   cfg_we cfg_data             quantile_prob
//
// values are taken one per cycle while the block is idle
// at column end the radix select makes 31 passes over the buffer, one per
// value bit, then interpolates between the two selected values
// an empty column skips the passes and loads its result directly
// the stored value count sets the pass length; reset needs no clearing pass
// a waiting result holds in the output register while new values load
module positive_value_quantile #(
    parameter int unsigned MAX_VALUES = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [16:0] cfg_data,     // quantile_prob
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,      // sample_value [31:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata       // anchor_value [30:0], positive_count [41:31],
                                      // none_positive [42], buffer_overflow [43]
);

    pvq_pkg::cmd_t    cmd;
    pvq_pkg::status_t status;

    // controller
    pvq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    pvq_dp #(
        .MAX_VALUES (MAX_VALUES)
    ) u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // column end stops input until the result is built
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input taken right after column end");

    // empty column result carries zero anchor and count
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[42]) |-> (m_tdata[41:0] == 42'd0))
        else $error("empty column result not zero");

    // load only into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !status.out_full)
        else $error("output overwritten");

endmodule

[sv/pvq_ctrl.sv]
// controller state machine for the positive value quantile block
module pvq_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tlast,
    output logic               s_tready,
    input  pvq_pkg::status_t   status,
    output pvq_pkg::cmd_t      cmd
);

    pvq_pkg::state_t state_reg;
    pvq_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pvq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            pvq_pkg::S_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && s_tlast)
                begin
                    state_next = pvq_pkg::S_POS;
                end
            end
            pvq_pkg::S_POS:
            begin
                cmd.start = 1'b1;
                if (status.count_zero)
                begin
                    state_next = pvq_pkg::S_OUT;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = pvq_pkg::S_SCAN;
                end
            end
            pvq_pkg::S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = pvq_pkg::S_DECIDE;
                end
            end
            pvq_pkg::S_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (status.bit_last)
                begin
                    state_next = pvq_pkg::S_MUL;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = pvq_pkg::S_SCAN;
                end
            end
            pvq_pkg::S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = pvq_pkg::S_SUM;
            end
            pvq_pkg::S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = pvq_pkg::S_OUT;
            end
            pvq_pkg::S_OUT:
            begin
                if (!status.out_full)
                begin
                    cmd.load   = 1'b1;
                    state_next = pvq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pvq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[sv/pvq_dp.sv]
// datapath: value buffer, radix select passes, interpolation, output register
module pvq_dp #(
    parameter int unsigned MAX_VALUES = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [16:0]        cfg_data,
    input  logic [31:0]        s_tdata,
    input  pvq_pkg::cmd_t      cmd,
    output pvq_pkg::status_t   status,
    output logic [47:0]        m_tdata,
    output logic               m_tvalid,
    input  logic               m_tready
);

    localparam int unsigned CW = $clog2(MAX_VALUES + 1);
    localparam int unsigned AW = $clog2(MAX_VALUES);
    localparam int unsigned PW = pvq_pkg::PROB_W + CW;
    localparam int unsigned MW = pvq_pkg::VALUE_W + pvq_pkg::FRAC_W;

    logic [pvq_pkg::VALUE_W-1:0] mem [MAX_VALUES];

    logic [CW-1:0]                count_reg;
    logic                         ovf_reg;
    logic [pvq_pkg::PROB_W-1:0]   prob_reg;
    logic [CW-1:0]                addr_reg;
    logic                         rvalid_reg;
    logic [pvq_pkg::VALUE_W-1:0]  rdata_reg;
    logic [CW-1:0]                cnt_lo_reg;
    logic [CW-1:0]                cnt_hi_reg;
    logic [CW-1:0]                rank_lo_reg;
    logic [CW-1:0]                rank_hi_reg;
    logic [pvq_pkg::VALUE_W-1:0]  pre_lo_reg;
    logic [pvq_pkg::VALUE_W-1:0]  pre_hi_reg;
    logic [4:0]                   bit_reg;
    logic [pvq_pkg::FRAC_W-1:0]   frac_reg;
    logic [MW-1:0]                prod_reg;
    logic [pvq_pkg::VALUE_W-1:0]  res_reg;
    logic                         out_valid_reg;
    logic [47:0]                  out_data_reg;

    logic                         positive;
    logic                         has_room;
    logic [pvq_pkg::PROB_W-1:0]   prob_sat;
    logic [PW-1:0]                pos;
    logic [CW-1:0]                lo;
    logic [CW-1:0]                lo_inc;
    logic [CW-1:0]                last_idx;
    logic [31:0]                  low_ones;
    logic [pvq_pkg::VALUE_W-1:0]  hi_mask;
    logic [pvq_pkg::VALUE_W-1:0]  bit_one;
    logic                         hit_lo;
    logic                         hit_hi;
    logic [MW:0]                  rounded;
    logic [31:0]                  sum_full;

    assign positive = (s_tdata != 32'd0) && !s_tdata[31];
    assign has_room = count_reg < CW'(MAX_VALUES);

    // position of the order statistics
    assign prob_sat = (prob_reg > pvq_pkg::PROB_ONE) ? pvq_pkg::PROB_ONE : prob_reg;
    assign last_idx = count_reg - CW'(1);
    assign pos      = PW'(prob_sat) * PW'(last_idx);
    assign lo       = pos[pvq_pkg::FRAC_W+CW-1:pvq_pkg::FRAC_W];
    assign lo_inc   = lo + CW'(1);

    // bits above the current one must match the prefix
    assign low_ones = (32'd2 << bit_reg) - 32'd1;
    assign hi_mask  = ~low_ones[pvq_pkg::VALUE_W-1:0];
    assign bit_one  = pvq_pkg::VALUE_W'(1) << bit_reg;
    assign hit_lo   = (((rdata_reg ^ pre_lo_reg) & hi_mask) == '0) && !rdata_reg[bit_reg];
    assign hit_hi   = (((rdata_reg ^ pre_hi_reg) & hi_mask) == '0) && !rdata_reg[bit_reg];

    // interpolation a + ((b - a) * f + half) >> 16
    assign rounded  = {1'b0, prod_reg} + (MW + 1)'(pvq_pkg::PROB_HALF);
    assign sum_full = 32'(pre_lo_reg) + 32'(rounded >> pvq_pkg::FRAC_W);

    // value buffer
    always_ff @(posedge clk)
    begin
        if (cmd.accept && positive && has_room)
        begin
            mem[count_reg[AW-1:0]] <= s_tdata[pvq_pkg::VALUE_W-1:0];
        end
        if (cmd.scan_step && (addr_reg < count_reg))
        begin
            rdata_reg <= mem[addr_reg[AW-1:0]];
        end
    end

    // column control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            prob_reg      <= pvq_pkg::PROB_HALF;
            addr_reg      <= '0;
            rvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                prob_reg <= cfg_data;
            end
            if (cmd.accept && positive)
            begin
                if (has_room)
                begin
                    count_reg <= count_reg + CW'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.load)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            if (cmd.scan_init)
            begin
                addr_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                addr_reg <= addr_reg + CW'(1);
            end
            rvalid_reg <= cmd.scan_step && (addr_reg < count_reg);
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // selection and arithmetic registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rank_lo_reg <= lo;
            rank_hi_reg <= (lo_inc < count_reg) ? lo_inc : last_idx;
            frac_reg    <= pos[pvq_pkg::FRAC_W-1:0];
            pre_lo_reg  <= '0;
            pre_hi_reg  <= '0;
            bit_reg     <= pvq_pkg::TOP_BIT;
        end
        if (cmd.scan_init)
        begin
            cnt_lo_reg <= '0;
            cnt_hi_reg <= '0;
        end
        else if (rvalid_reg)
        begin
            cnt_lo_reg <= cnt_lo_reg + CW'(hit_lo);
            cnt_hi_reg <= cnt_hi_reg + CW'(hit_hi);
        end
        if (cmd.decide)
        begin
            if (rank_lo_reg >= cnt_lo_reg)
            begin
                pre_lo_reg  <= pre_lo_reg | bit_one;
                rank_lo_reg <= rank_lo_reg - cnt_lo_reg;
            end
            if (rank_hi_reg >= cnt_hi_reg)
            begin
                pre_hi_reg  <= pre_hi_reg | bit_one;
                rank_hi_reg <= rank_hi_reg - cnt_hi_reg;
            end
            bit_reg <= bit_reg - 5'd1;
        end
        if (cmd.mul)
        begin
            prod_reg <= MW'(pre_hi_reg - pre_lo_reg) * MW'(frac_reg);
        end
        if (cmd.sum)
        begin
            res_reg <= sum_full[pvq_pkg::VALUE_W-1:0];
        end
        if (cmd.load)
        begin
            if (count_reg == '0)
            begin
                out_data_reg <= {4'd0, ovf_reg, 1'b1, 11'd0, 31'd0};
            end
            else
            begin
                out_data_reg <= {4'd0, ovf_reg, 1'b0,
                                 pvq_pkg::OCNT_W'(count_reg), res_reg};
            end
        end
    end

    assign status.scan_last  = addr_reg == count_reg;
    assign status.bit_last   = bit_reg == 5'd0;
    assign status.count_zero = count_reg == '0;
    assign status.out_full   = out_valid_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
